// File: sv/mlpbp_pkg.sv
package mlpbp_pkg;

  localparam int NIN    = 3;
  localparam int NHID   = 10;
  localparam int NIH    = NIN * NHID;
  localparam int OFS_HO = NIH;
  localparam int OFS_BH = NIH + NHID;
  localparam int IDX_OB = NIH + 2 * NHID;

  localparam int RATE_W = 15;
  localparam logic [RATE_W-1:0] RATE_RST = 15'd3686;

  localparam int MA_W  = 33;
  localparam int MB_W  = 24;
  localparam int MP_W  = MA_W + MB_W;
  localparam int ACC_W = 34;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_TRAIN = 3'd2;
  localparam logic [2:0] CMD_INFER = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] REG_RATE_IH = 2'd0;
  localparam logic [1:0] REG_RATE_HO = 2'd1;
  localparam logic [1:0] REG_RATE_HB = 2'd2;
  localparam logic [1:0] REG_RATE_OB = 2'd3;

  // sigmoid breakpoints s(k/4) in q12
  function automatic logic [11:0] sig_tab(input logic [5:0] k);
    logic [11:0] r;
    case (k)
      6'd0:  r = 12'd2048;
      6'd1:  r = 12'd2303;
      6'd2:  r = 12'd2550;
      6'd3:  r = 12'd2782;
      6'd4:  r = 12'd2994;
      6'd5:  r = 12'd3184;
      6'd6:  r = 12'd3349;
      6'd7:  r = 12'd3490;
      6'd8:  r = 12'd3608;
      6'd9:  r = 12'd3705;
      6'd10: r = 12'd3785;
      6'd11: r = 12'd3850;
      6'd12: r = 12'd3902;
      6'd13: r = 12'd3943;
      6'd14: r = 12'd3976;
      6'd15: r = 12'd4002;
      6'd16: r = 12'd4022;
      6'd17: r = 12'd4038;
      6'd18: r = 12'd4051;
      6'd19: r = 12'd4061;
      6'd20: r = 12'd4069;
      6'd21: r = 12'd4075;
      6'd22: r = 12'd4079;
      6'd23: r = 12'd4083;
      6'd24: r = 12'd4086;
      6'd25: r = 12'd4088;
      6'd26: r = 12'd4090;
      6'd27: r = 12'd4091;
      6'd28: r = 12'd4092;
      6'd29: r = 12'd4093;
      6'd30: r = 12'd4094;
      6'd31: r = 12'd4094;
      default: r = 12'd4095;
    endcase
    return r;
  endfunction

  // round half up, then arithmetic shift right
  function automatic logic signed [MP_W-1:0] rnd_sh(input logic signed [MP_W-1:0] v,
                                                    input int n);
    logic signed [MP_W-1:0] t;
    t = v + (MP_W'(1) <<< (n - 1));
    return t >>> n;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7FFF;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // parameter plus rounded step, saturated
  function automatic logic signed [15:0] upd16(input logic signed [15:0] w,
                                               input logic signed [MP_W-1:0] prod,
                                               input int n);
    logic signed [MP_W-1:0] d;
    d = rnd_sh(prod, n);
    return sat16(40'(w) + d[39:0]);
  endfunction

endpackage

// File: sv/mlp_backprop_trainer.sv
// channel  direction  tdata (lsb up)                                         tuser
// s_axis   in         feature_0 16, feature_1 16, feature_2 16, target 13,     command 3
//                     param_index 6, param_value 16, zero pad to 88
// m_axis   out        net_output 13, error_half 32, read_value 16, pad to 64  command_ok 1
// cfg      in         cfg_we_i, cfg_addr_i (register index), cfg_wdata_i (15 bits)
//
// write, read: an access state, then finish; clear and unknown commands finish directly.
// infer: each hidden unit, then the output: bias, multiply-accumulates, sigmoid. train adds
// error and parameter updates; every product uses the one shared 33x24 multiplier, registered.
// reset clears all weights, biases and the error sum at once; rates go to 3686.
// input is taken only when idle; a result still held stalls the next transaction at its end.
module mlp_backprop_trainer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // feature_0, feature_1, feature_2, target,
                                      // param_index, param_value
  input  logic [2:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // net_output, error_half, read_value
  output logic [0:0]  m_axis_tuser,   // command_ok
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [14:0] cfg_wdata_i
);

  localparam int JW  = (mlpbp_pkg::NHID > 1) ? $clog2(mlpbp_pkg::NHID) : 1;
  localparam int IW  = (mlpbp_pkg::NIN > 1) ? $clog2(mlpbp_pkg::NIN) : 1;
  localparam int KW  = (mlpbp_pkg::NIH > 1) ? $clog2(mlpbp_pkg::NIH) : 1;
  localparam int MAW = mlpbp_pkg::MA_W;
  localparam int MBW = mlpbp_pkg::MB_W;
  localparam int MPW = mlpbp_pkg::MP_W;
  localparam int AW  = mlpbp_pkg::ACC_W;
  localparam int RW  = mlpbp_pkg::RATE_W;

  localparam logic [5:0] ST_IDLE  = 6'd0;
  localparam logic [5:0] ST_RW    = 6'd1;
  localparam logic [5:0] ST_FBIAS = 6'd2;
  localparam logic [5:0] ST_FMUL  = 6'd3;
  localparam logic [5:0] ST_FACC  = 6'd4;
  localparam logic [5:0] ST_SIG1  = 6'd5;
  localparam logic [5:0] ST_SIG2  = 6'd6;
  localparam logic [5:0] ST_OBIAS = 6'd7;
  localparam logic [5:0] ST_OMUL  = 6'd8;
  localparam logic [5:0] ST_OACC  = 6'd9;
  localparam logic [5:0] ST_E1    = 6'd10;
  localparam logic [5:0] ST_E2    = 6'd11;
  localparam logic [5:0] ST_E3    = 6'd12;
  localparam logic [5:0] ST_WO1   = 6'd13;
  localparam logic [5:0] ST_WO2   = 6'd14;
  localparam logic [5:0] ST_WO3   = 6'd15;
  localparam logic [5:0] ST_WO4   = 6'd16;
  localparam logic [5:0] ST_H1    = 6'd17;
  localparam logic [5:0] ST_H2    = 6'd18;
  localparam logic [5:0] ST_H3    = 6'd19;
  localparam logic [5:0] ST_H4    = 6'd20;
  localparam logic [5:0] ST_H5    = 6'd21;
  localparam logic [5:0] ST_H6    = 6'd22;
  localparam logic [5:0] ST_H7    = 6'd23;
  localparam logic [5:0] ST_H8    = 6'd24;
  localparam logic [5:0] ST_SQ1   = 6'd25;
  localparam logic [5:0] ST_SQ2   = 6'd26;
  localparam logic [5:0] ST_OB    = 6'd27;
  localparam logic [5:0] ST_HB1   = 6'd28;
  localparam logic [5:0] ST_HB2   = 6'd29;
  localparam logic [5:0] ST_FIN   = 6'd30;

  logic [5:0] state_q, state_d;

  logic signed [15:0] w_ih_q [mlpbp_pkg::NIH];
  logic signed [15:0] w_ho_q [mlpbp_pkg::NHID];
  logic signed [15:0] b_h_q  [mlpbp_pkg::NHID];
  logic signed [15:0] b_o_q;
  logic [31:0]        err_sum_q;
  logic [RW-1:0]      rate_ih_q, rate_ho_q, rate_hb_q, rate_ob_q;

  logic [JW-1:0] j_q;
  logic [IW-1:0] i_q;
  logic [KW-1:0] k_q;
  logic          out_phase_q;
  logic          m_valid_q;

  logic [2:0]         cmd_q;
  logic signed [15:0] x_q [mlpbp_pkg::NIN];
  logic [12:0]        tgt_q;
  logic [5:0]         idx_q;
  logic signed [15:0] val_q;
  logic signed [AW-1:0]  acc_q;
  logic signed [MPW-1:0] prod_q;
  logic [11:0]        sg_base_q;
  logic               sg_neg_q;
  logic [12:0]        h_q [mlpbp_pkg::NHID];
  logic signed [15:0] p_q [mlpbp_pkg::NHID];
  logic [12:0]        y_q;
  logic signed [13:0] err_q;
  logic signed [13:0] q_q;
  logic [22:0]        t_q;
  logic signed [31:0] rq_q, rp_q;
  logic signed [15:0] rv_q;
  logic               ok_q;
  logic [12:0]        m_net_q;
  logic [31:0]        m_err_q;
  logic signed [15:0] m_rv_q;
  logic               m_ok_q;

  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;

  // parameter access decode
  logic [5:0]     ho_off, bh_off;
  logic [KW-1:0]  ih_addr;
  logic [JW-1:0]  ho_addr, bh_addr;
  logic signed [15:0] w_ih_rd, w_ho_rd, b_h_rd;
  logic           idx_ih, idx_ho, idx_bh, idx_ob;

  assign ho_off  = idx_q - 6'(mlpbp_pkg::OFS_HO);
  assign bh_off  = idx_q - 6'(mlpbp_pkg::OFS_BH);
  assign idx_ih  = idx_q < 6'(mlpbp_pkg::NIH);
  assign idx_ho  = !idx_ih && (idx_q < 6'(mlpbp_pkg::OFS_BH));
  assign idx_bh  = !idx_ih && !idx_ho && (idx_q < 6'(mlpbp_pkg::IDX_OB));
  assign idx_ob  = idx_q == 6'(mlpbp_pkg::IDX_OB);
  assign ih_addr = (state_q == ST_RW) ? idx_q[KW-1:0] : k_q;
  assign ho_addr = (state_q == ST_RW) ? ho_off[JW-1:0] : j_q;
  assign bh_addr = (state_q == ST_RW) ? bh_off[JW-1:0] : j_q;
  assign w_ih_rd = w_ih_q[ih_addr];
  assign w_ho_rd = w_ho_q[ho_addr];
  assign b_h_rd  = b_h_q[bh_addr];

  // sigmoid front end
  logic signed [AW-1:0] sg_x;
  logic signed [16:0]   sg_xc;
  logic [16:0]          sg_u;
  logic [11:0]          sg_lo, sg_hi, sg_base;
  logic [7:0]           sg_d;
  logic [12:0]          sg_s;
  logic [12:0]          sg_r;
  logic [MPW-1:0]       sg_frac_sum;

  always_comb begin
    sg_x = (acc_q + AW'(2048)) >>> 12;
    if (sg_x > AW'(32768)) begin
      sg_xc = 17'sd32768;
    end else if (sg_x < -AW'(32768)) begin
      sg_xc = -17'sd32768;
    end else begin
      sg_xc = sg_x[16:0];
    end
    sg_u  = sg_xc[16] ? 17'(-sg_xc) : 17'(sg_xc);
    sg_lo = mlpbp_pkg::sig_tab({1'b0, sg_u[14:10]});
    sg_hi = mlpbp_pkg::sig_tab(6'({1'b0, sg_u[14:10]} + 6'd1));
    if (sg_u[15]) begin
      sg_base = 12'd4095;
      sg_d    = 8'd0;
    end else begin
      sg_base = sg_lo;
      sg_d    = 8'(sg_hi - sg_lo);
    end
    sg_frac_sum = prod_q + MPW'(512);
    sg_s = 13'(sg_base_q) + 13'(sg_frac_sum[MPW-1:10]);
    sg_r = sg_neg_q ? 13'(13'd4096 - sg_s) : sg_s;
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_FMUL: begin
        mul_a = MAW'(w_ih_rd);
        mul_b = MBW'(x_q[i_q]);
      end
      ST_SIG1: begin
        mul_a = MAW'({1'b0, sg_d});
        mul_b = MBW'({1'b0, sg_u[9:0]});
      end
      ST_OMUL: begin
        mul_a = MAW'(w_ho_rd);
        mul_b = MBW'({1'b0, h_q[j_q]});
      end
      ST_E1: begin
        mul_a = MAW'({1'b0, y_q});
        mul_b = MBW'({1'b0, 13'(13'd4096 - y_q)});
      end
      ST_E2: begin
        mul_a = MAW'(err_q);
        mul_b = MBW'({1'b0, prod_q[22:0]});
      end
      ST_WO1: begin
        mul_a = MAW'({1'b0, rate_ho_q});
        mul_b = MBW'(q_q);
      end
      ST_WO3: begin
        mul_a = MAW'(rq_q);
        mul_b = MBW'({1'b0, h_q[j_q]});
      end
      ST_H1: begin
        mul_a = MAW'({1'b0, h_q[j_q]});
        mul_b = MBW'({1'b0, 13'(13'd4096 - h_q[j_q])});
      end
      ST_H2: begin
        mul_a = MAW'(q_q);
        mul_b = MBW'(w_ho_rd);
      end
      ST_H3: begin
        mul_a = MAW'($signed(prod_q[31:0]));
        mul_b = MBW'({1'b0, t_q});
      end
      ST_H5: begin
        mul_a = MAW'({1'b0, rate_ih_q});
        mul_b = MBW'(p_q[j_q]);
      end
      ST_H7: begin
        mul_a = MAW'(rp_q);
        mul_b = MBW'(x_q[i_q]);
      end
      ST_SQ1: begin
        mul_a = MAW'(err_q);
        mul_b = MBW'(err_q);
      end
      ST_SQ2: begin
        mul_a = MAW'({1'b0, rate_ob_q});
        mul_b = MBW'(q_q);
      end
      ST_HB1: begin
        mul_a = MAW'({1'b0, rate_hb_q});
        mul_b = MBW'(p_q[j_q]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic j_last, i_last;
  assign j_last = j_q == JW'(mlpbp_pkg::NHID - 1);
  assign i_last = i_q == IW'(mlpbp_pkg::NIN - 1);

  logic signed [MPW-1:0] sq_r;
  logic [32:0]           err_sum_nx;
  assign sq_r       = mlpbp_pkg::rnd_sh(prod_q, 8);
  assign err_sum_nx = {1'b0, err_sum_q} + {1'b0, sq_r[31:0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            mlpbp_pkg::CMD_WRITE: state_d = ST_RW;
            mlpbp_pkg::CMD_READ:  state_d = ST_RW;
            mlpbp_pkg::CMD_TRAIN: state_d = ST_FBIAS;
            mlpbp_pkg::CMD_INFER: state_d = ST_FBIAS;
            default:              state_d = ST_FIN;
          endcase
        end
      end
      ST_RW:    state_d = ST_FIN;
      ST_FBIAS: state_d = ST_FMUL;
      ST_FMUL:  state_d = ST_FACC;
      ST_FACC:  state_d = i_last ? ST_SIG1 : ST_FMUL;
      ST_SIG1:  state_d = ST_SIG2;
      ST_SIG2: begin
        if (!out_phase_q) begin
          state_d = j_last ? ST_OBIAS : ST_FBIAS;
        end else begin
          state_d = (cmd_q == mlpbp_pkg::CMD_TRAIN) ? ST_E1 : ST_FIN;
        end
      end
      ST_OBIAS: state_d = ST_OMUL;
      ST_OMUL:  state_d = ST_OACC;
      ST_OACC:  state_d = j_last ? ST_SIG1 : ST_OMUL;
      ST_E1:    state_d = ST_E2;
      ST_E2:    state_d = ST_E3;
      ST_E3:    state_d = ST_WO1;
      ST_WO1:   state_d = ST_WO2;
      ST_WO2:   state_d = ST_WO3;
      ST_WO3:   state_d = ST_WO4;
      ST_WO4:   state_d = j_last ? ST_H1 : ST_WO3;
      ST_H1:    state_d = ST_H2;
      ST_H2:    state_d = ST_H3;
      ST_H3:    state_d = ST_H4;
      ST_H4:    state_d = ST_H5;
      ST_H5:    state_d = ST_H6;
      ST_H6:    state_d = ST_H7;
      ST_H7:    state_d = ST_H8;
      ST_H8: begin
        if (!i_last) state_d = ST_H7;
        else state_d = j_last ? ST_SQ1 : ST_H1;
      end
      ST_SQ1:   state_d = ST_SQ2;
      ST_SQ2:   state_d = ST_OB;
      ST_OB:    state_d = ST_HB1;
      ST_HB1:   state_d = ST_HB2;
      ST_HB2:   state_d = j_last ? ST_FIN : ST_HB1;
      ST_FIN:   state_d = (!m_valid_q || m_axis_tready) ? ST_IDLE : ST_FIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control, parameters and error sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      out_phase_q <= 1'b0;
      m_valid_q   <= 1'b0;
      b_o_q       <= '0;
      err_sum_q   <= '0;
      rate_ih_q   <= mlpbp_pkg::RATE_RST;
      rate_ho_q   <= mlpbp_pkg::RATE_RST;
      rate_hb_q   <= mlpbp_pkg::RATE_RST;
      rate_ob_q   <= mlpbp_pkg::RATE_RST;
      for (int n = 0; n < mlpbp_pkg::NIH; n++) w_ih_q[n] <= '0;
      for (int n = 0; n < mlpbp_pkg::NHID; n++) begin
        w_ho_q[n] <= '0;
        b_h_q[n]  <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_addr_i)
          mlpbp_pkg::REG_RATE_IH: rate_ih_q <= cfg_wdata_i;
          mlpbp_pkg::REG_RATE_HO: rate_ho_q <= cfg_wdata_i;
          mlpbp_pkg::REG_RATE_HB: rate_hb_q <= cfg_wdata_i;
          mlpbp_pkg::REG_RATE_OB: rate_ob_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (state_q == ST_FIN && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
      else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          j_q         <= '0;
          out_phase_q <= 1'b0;
          if (s_axis_tvalid && s_axis_tuser == mlpbp_pkg::CMD_CLEAR) err_sum_q <= '0;
        end
        ST_RW: begin
          if (cmd_q == mlpbp_pkg::CMD_WRITE) begin
            if (idx_ih) w_ih_q[ih_addr] <= val_q;
            if (idx_ho) w_ho_q[ho_addr] <= val_q;
            if (idx_bh) b_h_q[bh_addr] <= val_q;
            if (idx_ob) b_o_q <= val_q;
          end
        end
        ST_FBIAS: begin
          i_q <= '0;
          k_q <= KW'(j_q);
        end
        ST_FACC: begin
          if (!i_last) begin
            i_q <= i_q + IW'(1);
            k_q <= k_q + KW'(mlpbp_pkg::NHID);
          end
        end
        ST_SIG2: begin
          if (!out_phase_q) begin
            j_q <= j_last ? '0 : j_q + JW'(1);
          end
        end
        ST_OACC: begin
          if (j_last) out_phase_q <= 1'b1;
          else j_q <= j_q + JW'(1);
        end
        ST_WO2: j_q <= '0;
        ST_WO4: begin
          w_ho_q[j_q] <= mlpbp_pkg::upd16(w_ho_rd, prod_q, 24);
          j_q <= j_last ? '0 : j_q + JW'(1);
        end
        ST_H6: begin
          i_q <= '0;
          k_q <= KW'(j_q);
        end
        ST_H8: begin
          w_ih_q[k_q] <= mlpbp_pkg::upd16(w_ih_rd, prod_q, 24);
          if (!i_last) begin
            i_q <= i_q + IW'(1);
            k_q <= k_q + KW'(mlpbp_pkg::NHID);
          end else begin
            j_q <= j_last ? '0 : j_q + JW'(1);
          end
        end
        ST_SQ2: begin
          err_sum_q <= err_sum_nx[32] ? 32'hFFFF_FFFF : err_sum_nx[31:0];
        end
        ST_OB: begin
          b_o_q <= mlpbp_pkg::upd16(b_o_q, prod_q, 12);
          j_q   <= '0;
        end
        ST_HB2: begin
          b_h_q[j_q] <= mlpbp_pkg::upd16(b_h_rd, prod_q, 12);
          j_q <= j_last ? '0 : j_q + JW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_q  <= s_axis_tuser;
          x_q[0] <= s_axis_tdata[15:0];
          if (mlpbp_pkg::NIN > 1) x_q[IW'(1 % mlpbp_pkg::NIN)] <= s_axis_tdata[31:16];
          if (mlpbp_pkg::NIN > 2) x_q[IW'(2 % mlpbp_pkg::NIN)] <= s_axis_tdata[47:32];
          tgt_q  <= s_axis_tdata[60:48];
          idx_q  <= s_axis_tdata[66:61];
          val_q  <= s_axis_tdata[82:67];
          y_q    <= '0;
          rv_q   <= '0;
          ok_q   <= (s_axis_tuser == mlpbp_pkg::CMD_TRAIN) ||
                    (s_axis_tuser == mlpbp_pkg::CMD_INFER) ||
                    (s_axis_tuser == mlpbp_pkg::CMD_CLEAR);
        end
      end
      ST_RW: begin
        ok_q <= idx_ih || idx_ho || idx_bh || idx_ob;
        if (cmd_q == mlpbp_pkg::CMD_READ) begin
          if (idx_ih) rv_q <= w_ih_rd;
          else if (idx_ho) rv_q <= w_ho_rd;
          else if (idx_bh) rv_q <= b_h_rd;
          else if (idx_ob) rv_q <= b_o_q;
        end
      end
      ST_FBIAS: acc_q <= AW'(b_h_rd) <<< 12;
      ST_FACC:  acc_q <= acc_q + prod_q[AW-1:0];
      ST_SIG1: begin
        sg_base_q <= sg_base;
        sg_neg_q  <= sg_xc[16];
      end
      ST_SIG2: begin
        if (!out_phase_q) h_q[j_q] <= sg_r;
        else y_q <= sg_r;
      end
      ST_OBIAS: acc_q <= AW'(b_o_q) <<< 12;
      ST_OACC:  acc_q <= acc_q + prod_q[AW-1:0];
      ST_E1:    err_q <= 14'({1'b0, tgt_q}) - 14'({1'b0, y_q});
      ST_E3:    q_q <= 14'(mlpbp_pkg::rnd_sh(prod_q, 24));
      ST_WO2:   rq_q <= prod_q[31:0];
      ST_H2:    t_q <= prod_q[22:0];
      ST_H4:    p_q[j_q] <= 16'(mlpbp_pkg::rnd_sh(prod_q, 36));
      ST_H6:    rp_q <= prod_q[31:0];
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_net_q <= y_q;
          m_err_q <= {1'b0, err_sum_q[31:1]};
          m_rv_q  <= rv_q;
          m_ok_q  <= ok_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_rv_q, m_err_q, m_net_q};
  assign m_axis_tuser  = m_ok_q;

endmodule
